FILE: src/fmp_pkg.sv
// Shared types, widths and microcode encodings for the Fibonacci/Pisano block.
package fmp_pkg;

  localparam int MOD_BITS  = 16;
  localparam int PER_BITS  = MOD_BITS + 3;
  localparam int IDX_BITS  = 64;
  localparam int CNT_BITS  = $clog2(IDX_BITS);
  localparam int PROG_LEN  = 7;
  localparam int UPC_BITS  = $clog2(PROG_LEN);

  typedef struct packed {
    logic [IDX_BITS-1:0] index;
    logic [MOD_BITS-1:0] modulus;
  } fmp_in_t;

  typedef struct packed {
    logic [MOD_BITS-1:0] residue;
    logic [PER_BITS-1:0] period;
  } fmp_out_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_PAIR_START,
    COND_CNT_ZERO,
    COND_K_ZERO,
    COND_OUT_FREE
  } cond_sel_t;

  typedef enum logic [1:0] {
    ACT_ALWAYS,
    ACT_IF_COND,
    ACT_IF_NOT
  } act_sel_t;

  // One microcode word: datapath enables, when they fire, and the jump.
  typedef struct packed {
    logic                in_rdy;
    logic                ld_in;
    logic                adv;
    logic                per_inc;
    logic                div_init;
    logic                div_step;
    logic                walk_init;
    logic                k_dec;
    logic                out_ld;
    act_sel_t            act;
    cond_sel_t           cond;
    logic [UPC_BITS-1:0] target;
  } ucode_t;

  // Qualified enables from the sequencer to the datapath.
  typedef struct packed {
    logic in_rdy;
    logic ld_in;
    logic adv;
    logic per_inc;
    logic div_init;
    logic div_step;
    logic walk_init;
    logic k_dec;
    logic out_ld;
  } fmp_ctrl_t;

  // Status from the datapath that the jump conditions test.
  typedef struct packed {
    logic pair_start;
    logic cnt_zero;
    logic k_zero;
  } fmp_flags_t;

endpackage

FILE: src/fmp_sequencer.sv
// Microcode store, step counter and jump logic.
module fmp_sequencer
  import fmp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  fmp_flags_t flags,
  input  logic       in_valid,
  input  logic       out_free,
  output fmp_ctrl_t  ctrl
);

  localparam logic [UPC_BITS-1:0] S_IDLE     = UPC_BITS'(0);
  localparam logic [UPC_BITS-1:0] S_SEARCH   = UPC_BITS'(1);
  localparam logic [UPC_BITS-1:0] S_DIVINIT  = UPC_BITS'(2);
  localparam logic [UPC_BITS-1:0] S_DIVSTEP  = UPC_BITS'(3);
  localparam logic [UPC_BITS-1:0] S_WALKINIT = UPC_BITS'(4);
  localparam logic [UPC_BITS-1:0] S_WALK     = UPC_BITS'(5);
  localparam logic [UPC_BITS-1:0] S_EMIT     = UPC_BITS'(6);

  // Fields: in_rdy ld_in adv per_inc div_init div_step walk_init k_dec out_ld act cond target
  localparam ucode_t PROG [PROG_LEN] = '{
    '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      ACT_IF_COND, COND_IN_VALID,   S_SEARCH},
    '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      ACT_ALWAYS,  COND_PAIR_START, S_DIVINIT},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
      ACT_ALWAYS,  COND_ALWAYS,     S_DIVSTEP},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
      ACT_ALWAYS,  COND_CNT_ZERO,   S_WALKINIT},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
      ACT_ALWAYS,  COND_ALWAYS,     S_WALK},
    '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
      ACT_IF_NOT,  COND_K_ZERO,     S_EMIT},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
      ACT_IF_COND, COND_OUT_FREE,   S_IDLE}
  };

  logic [UPC_BITS-1:0] upc_r;
  logic [UPC_BITS-1:0] upc_nxt;
  ucode_t              cw;
  logic                cond;
  logic                fire;

  assign cw = PROG[upc_r];

  always_comb begin
    unique case (cw.cond)
      COND_ALWAYS:     cond = 1'b1;
      COND_IN_VALID:   cond = in_valid;
      COND_PAIR_START: cond = flags.pair_start;
      COND_CNT_ZERO:   cond = flags.cnt_zero;
      COND_K_ZERO:     cond = flags.k_zero;
      COND_OUT_FREE:   cond = out_free;
      default:         cond = 1'b0;
    endcase
  end

  always_comb begin
    unique case (cw.act)
      ACT_ALWAYS:  fire = 1'b1;
      ACT_IF_COND: fire = cond;
      ACT_IF_NOT:  fire = !cond;
      default:     fire = 1'b0;
    endcase
  end

  // A word that is not satisfied holds the step counter in place.
  assign upc_nxt = cond ? cw.target : upc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign ctrl.in_rdy    = cw.in_rdy;
  assign ctrl.ld_in     = cw.ld_in     & fire;
  assign ctrl.adv       = cw.adv       & fire;
  assign ctrl.per_inc   = cw.per_inc   & fire;
  assign ctrl.div_init  = cw.div_init  & fire;
  assign ctrl.div_step  = cw.div_step  & fire;
  assign ctrl.walk_init = cw.walk_init & fire;
  assign ctrl.k_dec     = cw.k_dec     & fire;
  assign ctrl.out_ld    = cw.out_ld    & fire;

endmodule

FILE: src/fmp_datapath.sv
// Residue pair, period counter, bit-serial remainder and walk counter.
module fmp_datapath
  import fmp_pkg::*;
(
  input  logic       clk,
  input  fmp_ctrl_t  ctrl,
  input  fmp_in_t    in_data,
  output fmp_flags_t flags,
  output fmp_out_t   result
);

  logic [MOD_BITS-1:0] m_r;
  logic [MOD_BITS-1:0] a_r;
  logic [MOD_BITS-1:0] b_r;
  logic [PER_BITS-1:0] per_r;
  logic [IDX_BITS-1:0] n_r;
  logic [PER_BITS-1:0] rem_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [PER_BITS-1:0] k_r;

  logic [MOD_BITS-1:0] m_in;
  logic                start_in;
  logic                start_b;
  logic [MOD_BITS:0]   sum;
  logic [MOD_BITS:0]   sum_red;
  logic [MOD_BITS-1:0] b_adv;
  logic [PER_BITS:0]   shifted;
  logic [PER_BITS:0]   shifted_red;

  // A zero modulus is handled as modulus one.
  assign m_in     = (in_data.modulus == '0) ? MOD_BITS'(1) : in_data.modulus;
  assign start_in = (m_in != MOD_BITS'(1));
  assign start_b  = (m_r != MOD_BITS'(1));

  // Both operands are below m, so one conditional subtract reduces the sum.
  assign sum     = {1'b0, a_r} + {1'b0, b_r};
  assign sum_red = (sum >= {1'b0, m_r}) ? (sum - {1'b0, m_r}) : sum;
  assign b_adv   = sum_red[MOD_BITS-1:0];

  assign shifted     = {rem_r, n_r[cnt_r]};
  assign shifted_red = (shifted >= {1'b0, per_r}) ? (shifted - {1'b0, per_r}) : shifted;

  always_ff @(posedge clk) begin
    if (ctrl.ld_in) begin
      m_r   <= m_in;
      n_r   <= in_data.index;
      a_r   <= '0;
      b_r   <= MOD_BITS'(start_in);
      per_r <= '0;
    end
    if (ctrl.walk_init) begin
      a_r <= '0;
      b_r <= MOD_BITS'(start_b);
      k_r <= rem_r;
    end
    if (ctrl.adv) begin
      a_r <= b_r;
      b_r <= b_adv;
    end
    if (ctrl.per_inc) begin
      per_r <= per_r + PER_BITS'(1);
    end
    if (ctrl.k_dec) begin
      k_r <= k_r - PER_BITS'(1);
    end
    if (ctrl.div_init) begin
      rem_r <= '0;
      cnt_r <= CNT_BITS'(IDX_BITS - 1);
    end
    if (ctrl.div_step) begin
      rem_r <= shifted_red[PER_BITS-1:0];
      cnt_r <= cnt_r - CNT_BITS'(1);
    end
  end

  // The start pair is (0, start_b); the test looks at the pair being formed.
  assign flags.pair_start = (b_r == '0) && (b_adv == MOD_BITS'(start_b));
  assign flags.cnt_zero   = (cnt_r == '0);
  assign flags.k_zero     = (k_r == '0);

  assign result.residue = a_r;
  assign result.period  = per_r;

endmodule

FILE: src/fibonacci_mod_pisano.sv
// Top level: Fibonacci residue modulo m together with the Pisano period of m.
//
// The input channel (in_valid, in_ready, in_data) takes one beat holding a
// 64-bit index n and a 16-bit modulus m. The result channel (out_valid,
// out_ready, out_data) returns one beat per input with F(n) mod m and the
// Pisano period P of m. A modulus of zero is treated as one, which gives
// residue 0 and period 1.
// Work is done by a small microcoded sequencer. With P the period, an item
// goes through these steps: a walk of the residue pair until the start pair
// recurs, setup and the bit-serial remainder of n by P, setup of the second
// walk, and that walk from the start pair to F(n mod P) mod m. P is at most
// 6m. The one-step modular add of the residue pair sets the pace of both walks.
// Items are processed one at a time; in_ready is high only while the
// sequencer waits for a new beat. A finished result sits in the output
// register, so the next item is accepted and started while the receiver
// stalls; that item's result waits until the register is free.
// Reset clears the sequencer to its idle step and empties the output register.
module fibonacci_mod_pisano
  import fmp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  fmp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output fmp_out_t out_data
);

  fmp_ctrl_t  ctrl;
  fmp_flags_t flags;
  fmp_out_t   result;
  logic       out_free;
  logic       out_valid_r;
  fmp_out_t   out_data_r;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || out_ready;

  fmp_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .flags    (flags),
    .in_valid (in_valid),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  fmp_datapath u_dp (
    .clk     (clk),
    .ctrl    (ctrl),
    .in_data (in_data),
    .flags   (flags),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_ld) begin
      out_data_r <= result;
    end
  end

  assign in_ready  = ctrl.in_rdy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A stalled result is not dropped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r)
    else $error("result beat lost while stalled");

  // Every delivered period is at least one.
  a_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.period != '0))
    else $error("zero period on result");

  // After a beat is taken the sequencer is busy with it.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // A result is never loaded in the same cycle as a new input.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_ld |-> !ctrl.ld_in && !in_ready)
    else $error("load and emit overlap");

endmodule

FILE: dv/fibonacci_mod_pisano_tb.sv
// Self-checking testbench for the Fibonacci-residue / Pisano-period block.
`timescale 1ns / 100ps

module fibonacci_mod_pisano_tb;
  import fmp_pkg::*;

  // One beat waiting to be driven. The drain flag holds the beat back until
  // every earlier result has come out. The idle flag enables random idling
  // on both sides while the beat is in flight.
  typedef struct packed {
    fmp_in_t beat;
    logic    drain;
    logic    idle_en;
  } queued_beat_t;

  localparam int RAND_ITEMS  = 80;
  localparam int QUIET_TAIL  = 15;
  localparam int FLUSH_WAIT  = 300;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  fmp_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  fmp_out_t out_data;

  queued_beat_t pending_beats[$];
  fmp_out_t     expected_results[$];
  queued_beat_t next_beat;
  fmp_out_t     want;

  int          items_sent   = 0;
  int          results_seen = 0;
  int          total_items  = 0;
  int          fail_count   = 0;
  int          src_gap      = 0;
  int          snk_gap      = 0;
  logic        idle_en_r    = 1'b1;
  longint      cycle_count  = 0;
  longint      cycle_limit  = 0;
  int unsigned max_modulus  = 0;
  int unsigned max_period   = 0;

  fibonacci_mod_pisano dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Works out F(index) mod modulus and the Pisano period of the modulus.
  // The period is found by stepping the residue pair from (0, 1 mod m) until
  // that pair comes back; the residue is then the first element of the pair
  // after (index mod period) steps. A zero modulus behaves like a modulus of
  // one, so both give residue 0 and period 1.
  function automatic fmp_out_t fib_pisano_predict(fmp_in_t item);
    logic [31:0] modv;
    logic [31:0] seed;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] s;
    logic [31:0] per;
    logic [63:0] steps;
    logic [63:0] k;
    fmp_out_t    res;
    modv = {16'd0, item.modulus};
    if (modv == 0) begin
      modv = 1;
    end
    seed = 1 % modv;
    a    = 0;
    b    = seed;
    per  = 0;
    do begin
      s   = (a + b) % modv;
      a   = b;
      b   = s;
      per = per + 1;
    end while (!(a == 0 && b == seed));
    steps = item.index % {32'd0, per};
    a     = 0;
    b     = seed;
    for (k = 0; k < steps; k++) begin
      s = (a + b) % modv;
      a = b;
      b = s;
    end
    res.residue = a[MOD_BITS-1:0];
    res.period  = per[PER_BITS-1:0];
    return res;
  endfunction

  // Queues one beat and adds its worst-case cost to the cycle budget. The
  // block walks the residue pair over one full period and again up to the
  // index reduced mod the period, and the period never exceeds six times the
  // modulus; the margin covers the longest idle bursts on both sides.
  task automatic queue_item(input logic [IDX_BITS-1:0] idx, input logic [MOD_BITS-1:0] modv,
                            input logic drain, input logic idle);
    queued_beat_t qb;
    longint       m_eff;
    qb.beat.index   = idx;
    qb.beat.modulus = modv;
    qb.drain        = drain;
    qb.idle_en      = idle;
    pending_beats   = {pending_beats, qb};
    total_items++;
    m_eff = (modv == 0) ? 1 : longint'(modv);
    cycle_limit += 12 * m_eff + 200;
    if (32'(modv) > max_modulus) begin
      max_modulus = 32'(modv);
    end
  endtask

  // Driver: presents one beat at a time and keeps it stable until the block
  // takes it. The expected result is computed at the moment of acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      src_gap    <= 0;
      items_sent <= 0;
      idle_en_r  <= 1'b1;
    end else begin
      if (in_valid && in_ready) begin
        expected_results = {expected_results, fib_pisano_predict(in_data)};
        items_sent <= items_sent + 1;
      end
      // The channel is free when nothing is presented or the beat just went.
      if (!in_valid || in_ready) begin
        if (src_gap != 0 && idle_en_r) begin
          in_valid <= 1'b0;
          src_gap  <= src_gap - 1;
        end else if (pending_beats.size() != 0 &&
                     !(pending_beats[0].drain && (in_valid || items_sent != results_seen))) begin
          next_beat = pending_beats.pop_front();
          in_valid  <= 1'b1;
          in_data   <= next_beat.beat;
          idle_en_r <= next_beat.idle_en;
          src_gap   <= (next_beat.idle_en && $urandom_range(0, 2) == 0) ?
                       int'($urandom_range(1, 9)) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest expectation and
  // throttles out_ready with random stall bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready    <= 1'b0;
      snk_gap      <= 0;
      results_seen <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $error("result beat with no item outstanding: residue %0d period %0d",
                 out_data.residue, out_data.period);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.residue !== want.residue) begin
            $error("residue: expected %0d, got %0d", want.residue, out_data.residue);
            fail_count++;
          end
          if (out_data.period !== want.period) begin
            $error("period: expected %0d, got %0d", want.period, out_data.period);
            fail_count++;
          end
          if (32'(want.period) > max_period) begin
            max_period = 32'(want.period);
          end
        end
      end
      if (snk_gap != 0 && idle_en_r) begin
        out_ready <= 1'b0;
        snk_gap   <= snk_gap - 1;
      end else if (idle_en_r && $urandom_range(0, 15) == 0) begin
        // Start a stall burst.
        out_ready <= 1'b0;
        snk_gap   <= int'($urandom_range(0, 8));
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on the budget built up while queueing.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= cycle_limit) begin
      $display("Timeout after %0d cycles with %0d of %0d results received",
               cycle_count, results_seen, total_items);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int          i;
    logic        chunk_idle;
    int unsigned pick;
    logic [15:0] modv;
    logic [63:0] idx;

    // Directed corners. A modulus of one starts at the pair (0,0), and a
    // zero modulus must behave the same way.
    queue_item(64'd0, 16'd1, 1'b0, 1'b1);
    queue_item(64'hFFFF_FFFF_FFFF_FFFF, 16'd1, 1'b0, 1'b1);
    queue_item(64'd12345, 16'd0, 1'b0, 1'b1);
    queue_item(64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 1'b0, 1'b1);
    // This one waits until the pipe is empty before it is offered.
    queue_item(64'd0, 16'd2, 1'b1, 1'b1);
    queue_item(64'd1, 16'd2, 1'b0, 1'b1);
    queue_item(64'd10, 16'd10, 1'b0, 1'b1);
    // Period of 10 is 60: indexes just below, at and above one full cycle.
    queue_item(64'd59, 16'd10, 1'b0, 1'b1);
    queue_item(64'd60, 16'd10, 1'b0, 1'b1);
    queue_item(64'd61, 16'd10, 1'b0, 1'b1);
    queue_item(64'd2015, 16'd3, 1'b0, 1'b1);
    queue_item(64'd239, 16'd1000, 1'b0, 1'b0);
    queue_item(64'd1, 16'd1, 1'b0, 1'b0);
    // All-ones, single-bit and other wide moduli, with indexes from zero to the widest.
    queue_item(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b0, 1'b1);
    queue_item(64'd0, 16'hFFFF, 1'b0, 1'b1);
    queue_item(64'h8000_0000_0000_0000, 16'h8000, 1'b0, 1'b1);
    queue_item(64'd1, 16'hFFFE, 1'b0, 1'b1);
    queue_item(64'h5555_5555_5555_5555, 16'hAAAA, 1'b0, 1'b1);
    queue_item(64'hAAAA_AAAA_AAAA_AAAA, 16'h5555, 1'b0, 1'b1);
    // 31250 has a period of six times m, the largest ratio of period to modulus.
    queue_item(64'h7FFF_FFFF_FFFF_FFFF, 16'd31250, 1'b0, 1'b1);

    // Random part. Most moduli are small so the run stays short; a few are
    // drawn from the full range. Idling is switched per chunk of ten items
    // and is off for the final stretch.
    chunk_idle = 1'b1;
    for (i = 0; i < RAND_ITEMS; i++) begin
      if (i % 10 == 0) begin
        chunk_idle = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        modv = 16'($urandom_range(0, 65535));
      end else if (pick < 14) begin
        modv = 16'($urandom_range(256, 4095));
      end else begin
        modv = 16'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 3) == 0) begin
        idx = 64'($urandom_range(0, 1000));
      end else begin
        idx = {$urandom, $urandom};
      end
      queue_item(idx, modv, (i == RAND_ITEMS / 2),
                 chunk_idle && (i < RAND_ITEMS - QUIET_TAIL));
    end
    cycle_limit = 4 * cycle_limit + 10000;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (items_sent != total_items || results_seen != items_sent) begin
      @(posedge clk);
    end
    // Give a stray extra beat time to show up before closing.
    repeat (FLUSH_WAIT) @(posedge clk);

    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      fail_count++;
    end
    $display("Checked %0d items (%0d directed corners, %0d random) with moduli up to %0d",
             results_seen, total_items - RAND_ITEMS, RAND_ITEMS, max_modulus);
    $display("Longest Pisano period seen: %0d; %0d mismatches", max_period, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
